@@ hdl/tpps_pkg.sv @@
// tpps_pkg: shared widths, result select codes and control structs for the
// timed pattern playback sequencer. No dependencies.
`default_nettype none

package tpps_pkg;

    localparam int WORD_W     = 64;
    localparam int DUR_W      = 16;
    localparam int FRAME_W    = 16;
    localparam int IDX_W      = 8;
    localparam int COUNT_W    = 9;
    localparam int MAX_ENTRIES = 256;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = IDX_W + DUR_W + WORD_W + FRAME_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_WORD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WORD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_IN      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 2'd3;

    // request kinds carried on tuser
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FRAME = 1'b1;

    // which word a finished frame request returns
    localparam logic [1:0] SEL_FIRST   = 2'd0;
    localparam logic [1:0] SEL_DEFAULT = 2'd1;
    localparam logic [1:0] SEL_TABLE   = 2'd2;

    typedef struct packed {
        logic               start;
        logic [FRAME_W-1:0] frame;
    } t_seq_cmd;

    typedef struct packed {
        logic       idle;
        logic       done;
        logic [1:0] sel;
    } t_seq_stat;

endpackage

`default_nettype wire

@@ hdl/timed_pattern_playback_sequencer.sv @@
// Timed pattern playback sequencer, top level: configuration registers,
// stream handshakes and output register. Depends on tpps_pkg, tpps_table, tpps_seq.
//
// s_axis carries requests. tuser = 0 loads table entry entry_index with a
// duration and an output word; it is written when accepted and returns nothing.
// tuser = 1 asks for the word of frame_number and returns one m_axis item.
// The cfg channel writes default_word, first_frame_word, lead_in_frames and
// entry_count (indexes 0 to 3); it is always ready. The user must write it only
// while idle; the block does not enforce this. Frame requests run on a small
// sequencer around one shared 16-bit adder. Frame 0, lead-in frames, a repeated
// frame and the empty table need no walk. Otherwise the sequencer checks, past
// leading zero-duration entries, that some entry is live, then passes entries,
// skips zero-duration entries and handles tick-count wraps; ticks inside one
// entry are added in one step. s_axis_tready is low meanwhile.
// A result waits in the output register while m_axis is stalled; a next
// frame request then finishes its walk and holds until that register drains.
// Reset (synchronous, active low) clears the playback position, output valid and
// configuration, but sets lead_in_frames to 283; table contents are kept.
`default_nettype none

module timed_pattern_playback_sequencer (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // request stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [7:0] entry_index, [23:8] entry_duration, [87:24] entry_word,
    // [103:88] frame_number
    input  wire logic [tpps_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [0] req_type
    input  wire logic                               s_axis_tuser,
    // result stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [63:0] out_word
    output logic      [tpps_pkg::WORD_W-1:0]        m_axis_tdata,
    // configuration writes
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [tpps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [tpps_pkg::WORD_W-1:0]        i_cfg_data
);

    localparam int IW = tpps_pkg::IDX_W;
    localparam int DW = tpps_pkg::DUR_W;
    localparam int WW = tpps_pkg::WORD_W;
    localparam int FW = tpps_pkg::FRAME_W;
    localparam int CW = tpps_pkg::COUNT_W;

    logic [WW-1:0] r_default_word;
    logic [WW-1:0] r_first_word;
    logic [FW-1:0] r_lead_in;
    logic [CW-1:0] r_entry_count;
    logic          r_out_valid;
    logic [WW-1:0] r_out_data;

    logic                 in_fire;
    logic                 load_fire;
    logic                 slot_free;
    logic [CW-1:0]        used_count;
    logic [IW-1:0]        rd_addr;
    logic [DW-1:0]        rd_dur;
    logic [WW-1:0]        rd_word;
    logic [IW-1:0]        in_index;
    logic [DW-1:0]        in_duration;
    logic [WW-1:0]        in_word;
    logic [FW-1:0]        in_frame;
    tpps_pkg::t_seq_cmd   seq_cmd;
    tpps_pkg::t_seq_stat  seq_stat;

    always_comb begin
        in_index    = s_axis_tdata[IW-1:0];
        in_duration = s_axis_tdata[IW+DW-1:IW];
        in_word     = s_axis_tdata[IW+DW+WW-1:IW+DW];
        in_frame    = s_axis_tdata[IW+DW+WW+FW-1:IW+DW+WW];

        s_axis_tready = seq_stat.idle;
        in_fire       = s_axis_tvalid && s_axis_tready;
        load_fire     = in_fire && (s_axis_tuser == tpps_pkg::REQ_LOAD);
        seq_cmd.start = in_fire && (s_axis_tuser == tpps_pkg::REQ_FRAME);
        seq_cmd.frame = in_frame;

        slot_free     = !r_out_valid || m_axis_tready;
        used_count    = (r_entry_count > CW'(tpps_pkg::MAX_ENTRIES))
                        ? CW'(tpps_pkg::MAX_ENTRIES) : r_entry_count;

        m_axis_tvalid = r_out_valid;
        m_axis_tdata  = r_out_data;
        o_cfg_ready   = 1'b1;
    end

    tpps_table u_table (
        .i_clk     (i_clk),
        .i_wr_en   (load_fire),
        .i_wr_addr (in_index),
        .i_wr_dur  (in_duration),
        .i_wr_word (in_word),
        .i_rd_addr (rd_addr),
        .o_rd_dur  (rd_dur),
        .o_rd_word (rd_word)
    );

    tpps_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (seq_cmd),
        .i_lead_in   (r_lead_in),
        .i_count     (used_count),
        .i_slot_free (slot_free),
        .i_rd_dur    (rd_dur),
        .o_rd_addr   (rd_addr),
        .o_stat      (seq_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_word <= '0;
            r_first_word   <= '0;
            r_lead_in      <= 16'd283;
            r_entry_count  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tpps_pkg::CFG_DEFAULT_WORD: r_default_word <= i_cfg_data;
                tpps_pkg::CFG_FIRST_WORD:   r_first_word   <= i_cfg_data;
                tpps_pkg::CFG_LEAD_IN:      r_lead_in      <= i_cfg_data[FW-1:0];
                tpps_pkg::CFG_ENTRY_COUNT:  r_entry_count  <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // output register: loaded by the sequencer only when it is free or draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_stat.done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (seq_stat.done) begin
            case (seq_stat.sel)
                tpps_pkg::SEL_FIRST:   r_out_data <= r_first_word;
                tpps_pkg::SEL_DEFAULT: r_out_data <= r_default_word;
                tpps_pkg::SEL_TABLE:   r_out_data <= rd_word;
                default:               r_out_data <= r_default_word;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hdl/tpps_table.sv @@
// tpps_table: duration and word memories of the playback table, one write
// port and one registered read port. Depends on tpps_pkg.
`default_nettype none

module tpps_table (
    input  wire logic                         i_clk,
    input  wire logic                         i_wr_en,
    input  wire logic [tpps_pkg::IDX_W-1:0]   i_wr_addr,
    input  wire logic [tpps_pkg::DUR_W-1:0]   i_wr_dur,
    input  wire logic [tpps_pkg::WORD_W-1:0]  i_wr_word,
    input  wire logic [tpps_pkg::IDX_W-1:0]   i_rd_addr,
    output logic      [tpps_pkg::DUR_W-1:0]   o_rd_dur,
    output logic      [tpps_pkg::WORD_W-1:0]  o_rd_word
);

    logic [tpps_pkg::DUR_W-1:0]  r_dur_mem  [tpps_pkg::MAX_ENTRIES];
    logic [tpps_pkg::WORD_W-1:0] r_word_mem [tpps_pkg::MAX_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_dur_mem[i_wr_addr]  <= i_wr_dur;
            r_word_mem[i_wr_addr] <= i_wr_word;
        end
        o_rd_dur  <= r_dur_mem[i_rd_addr];
        o_rd_word <= r_word_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

@@ hdl/tpps_alu.sv @@
// tpps_alu: the one shared 16-bit add/subtract unit of the sequencer;
// bit 16 is the carry, set on subtract when a >= b. Depends on tpps_pkg.
`default_nettype none

module tpps_alu (
    input  wire logic [tpps_pkg::DUR_W-1:0] i_a,
    input  wire logic [tpps_pkg::DUR_W-1:0] i_b,
    input  wire logic                       i_sub,
    output logic      [tpps_pkg::DUR_W:0]   o_sum
);

    logic [tpps_pkg::DUR_W-1:0] b_op;

    always_comb begin
        b_op  = i_sub ? ~i_b : i_b;
        o_sum = {1'b0, i_a} + {1'b0, b_op} + {{tpps_pkg::DUR_W{1'b0}}, i_sub};
    end

endmodule

`default_nettype wire

@@ hdl/tpps_seq.sv @@
// tpps_seq: frame request sequencer; walks the table one step per state
// through the shared tpps_alu. Depends on tpps_pkg and tpps_alu.
`default_nettype none

module tpps_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tpps_pkg::t_seq_cmd            i_cmd,
    input  wire logic [tpps_pkg::FRAME_W-1:0]  i_lead_in,
    input  wire logic [tpps_pkg::COUNT_W-1:0]  i_count,
    input  wire logic                          i_slot_free,
    input  wire logic [tpps_pkg::DUR_W-1:0]    i_rd_dur,
    output logic      [tpps_pkg::IDX_W-1:0]    o_rd_addr,
    output tpps_pkg::t_seq_stat                o_stat
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCRIPT = 4'd1;
    localparam logic [3:0] S_DIFF   = 4'd2;
    localparam logic [3:0] S_BULK   = 4'd3;
    localparam logic [3:0] S_SCAN   = 4'd4;
    localparam logic [3:0] S_SCHK   = 4'd5;
    localparam logic [3:0] S_LOAD   = 4'd6;
    localparam logic [3:0] S_TICK   = 4'd7;
    localparam logic [3:0] S_JUMP   = 4'd8;
    localparam logic [3:0] S_ADDT   = 4'd9;
    localparam logic [3:0] S_NEXT   = 4'd10;
    localparam logic [3:0] S_SKIP   = 4'd11;
    localparam logic [3:0] S_WORD   = 4'd12;
    localparam logic [3:0] S_FIN    = 4'd13;

    localparam int DW = tpps_pkg::DUR_W;
    localparam int IW = tpps_pkg::IDX_W;

    logic [3:0]                      r_state, n_state;
    logic [tpps_pkg::FRAME_W-1:0]    r_frame, n_frame;
    logic [DW-1:0]                   r_script, n_script;
    logic [DW-1:0]                   r_last, n_last;
    logic [DW-1:0]                   r_adv, n_adv;
    logic [DW-1:0]                   r_ticks, n_ticks;
    logic [DW-1:0]                   r_k, n_k;
    logic [IW-1:0]                   r_cur, n_cur;
    logic [IW-1:0]                   r_idx, n_idx;
    logic                            r_single, n_single;
    logic                            r_stay, n_stay;
    logic [1:0]                      r_sel, n_sel;

    logic [DW-1:0] alu_a, alu_b;
    logic          alu_sub;
    logic [DW:0]   alu_sum;
    logic          empty;
    logic          cur_out;
    logic [IW-1:0] cur_next;

    tpps_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_sum (alu_sum)
    );

    always_comb begin
        empty    = (i_count == '0);
        cur_out  = ({1'b0, r_cur} >= i_count);
        cur_next = (({1'b0, r_cur} + 9'd1) == i_count) ? '0 : r_cur + 8'd1;
    end

    // operand selection for the shared unit
    always_comb begin
        alu_a   = r_ticks;
        alu_b   = r_adv;
        alu_sub = 1'b0;
        case (r_state)
            S_SCRIPT: begin
                alu_a   = r_frame;
                alu_b   = i_lead_in;
                alu_sub = 1'b1;
            end
            S_DIFF: begin
                alu_a   = r_script;
                alu_b   = r_last;
                alu_sub = 1'b1;
            end
            S_TICK: begin
                alu_a   = i_rd_dur;
                alu_b   = r_ticks;
                alu_sub = 1'b1;
            end
            S_JUMP: begin
                alu_a   = r_adv;
                alu_b   = r_single ? 16'd1 : r_k;
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = r_ticks;
                alu_b   = r_adv;
                alu_sub = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_frame  = r_frame;
        n_script = r_script;
        n_last   = r_last;
        n_adv    = r_adv;
        n_ticks  = r_ticks;
        n_k      = r_k;
        n_cur    = r_cur;
        n_idx    = r_idx;
        n_single = r_single;
        n_stay   = r_stay;
        n_sel    = r_sel;
        o_rd_addr = r_cur;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_frame = i_cmd.frame;
                    n_state = S_SCRIPT;
                end
            end
            S_SCRIPT: begin
                if (r_frame == '0) begin
                    n_sel   = tpps_pkg::SEL_FIRST;
                    n_state = S_FIN;
                end else if (!alu_sum[DW]) begin
                    n_sel   = tpps_pkg::SEL_DEFAULT;
                    n_state = S_FIN;
                end else begin
                    n_script = alu_sum[DW-1:0];
                    n_state  = S_DIFF;
                end
            end
            S_DIFF: begin
                if (alu_sum[DW-1:0] == '0) begin
                    if (empty) begin
                        n_sel   = tpps_pkg::SEL_DEFAULT;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_WORD;
                    end
                end else begin
                    n_last = r_script;
                    n_adv  = alu_sum[DW-1:0];
                    if (empty || cur_out) begin
                        n_state = S_BULK;
                    end else begin
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_BULK: begin
                n_ticks = alu_sum[DW-1:0];
                if (empty) begin
                    n_sel   = tpps_pkg::SEL_DEFAULT;
                    n_state = S_FIN;
                end else begin
                    n_state = S_WORD;
                end
            end
            // look for any entry in use with a nonzero duration
            S_SCAN: begin
                o_rd_addr = r_idx;
                n_state   = S_SCHK;
            end
            S_SCHK: begin
                if (i_rd_dur != '0) begin
                    n_state = S_LOAD;
                end else if (({1'b0, r_idx} + 9'd1) == i_count) begin
                    n_cur   = '0;
                    n_ticks = '0;
                    n_state = S_WORD;
                end else begin
                    n_idx   = r_idx + 8'd1;
                    n_state = S_SCAN;
                end
            end
            S_LOAD: begin
                n_state = S_TICK;
            end
            // k = duration - ticks; ticks left in this entry when k >= 2
            S_TICK: begin
                n_k      = alu_sum[DW-1:0];
                n_single = !(alu_sum[DW] && (alu_sum[DW-1:1] != '0));
                n_stay   = (r_ticks == {DW{1'b1}}) && (i_rd_dur != '0);
                n_state  = S_JUMP;
            end
            S_JUMP: begin
                if (!r_single && !alu_sum[DW]) begin
                    n_state = S_ADDT;
                end else begin
                    n_adv   = alu_sum[DW-1:0];
                    n_ticks = '0;
                    if (r_single && r_stay) begin
                        n_state = (alu_sum[DW-1:0] == '0) ? S_WORD : S_TICK;
                    end else begin
                        n_state = S_NEXT;
                    end
                end
            end
            S_ADDT: begin
                n_ticks = alu_sum[DW-1:0];
                n_state = S_WORD;
            end
            S_NEXT: begin
                n_cur     = cur_next;
                o_rd_addr = cur_next;
                n_state   = S_SKIP;
            end
            S_SKIP: begin
                if (i_rd_dur == '0) begin
                    n_state = S_NEXT;
                end else if (r_adv == '0) begin
                    n_state = S_WORD;
                end else begin
                    n_state = S_TICK;
                end
            end
            S_WORD: begin
                n_sel   = tpps_pkg::SEL_TABLE;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_stat.idle = (r_state == S_IDLE);
        o_stat.done = (r_state == S_FIN) && i_slot_free;
        o_stat.sel  = r_sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= '0;
            r_cur   <= '0;
            r_ticks <= '0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            r_cur   <= n_cur;
            r_ticks <= n_ticks;
        end
        r_frame  <= n_frame;
        r_script <= n_script;
        r_adv    <= n_adv;
        r_k      <= n_k;
        r_idx    <= n_idx;
        r_single <= n_single;
        r_stay   <= n_stay;
        r_sel    <= n_sel;
    end

    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stat.idle && i_cmd.start) |=> !o_stat.idle)
        else $error("frame request did not start the sequencer");

    a_tick_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK) |-> ({1'b0, r_cur} < i_count))
        else $error("playback entry beyond entry count");

    a_advance_clears_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NEXT) |-> (r_ticks == '0))
        else $error("entry advanced with ticks left");

    a_done_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.done |-> (i_slot_free && (r_state == S_FIN)))
        else $error("result issued while output slot busy");

endmodule

`default_nettype wire
